/* design/mbp_pkg.sv */
// Package for the two-layer perceptron trainer/predictor.
// Holds item structs, sizes, controller command struct and Q4.12 helpers.
package mbp_pkg;

  localparam int unsigned N_IN  = 2;
  localparam int unsigned N_HID = 3;
  localparam int unsigned N_OUT = 3;
  localparam int unsigned W1_N  = (N_IN + 1) * N_HID;
  localparam int unsigned W2_N  = (N_HID + 1) * N_OUT;
  localparam int unsigned W_N   = W1_N + W2_N;
  localparam logic signed [15:0] ONE_Q = 16'sd4096;

  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_TRAIN   = 2'd1;
  localparam logic [1:0] KIND_PREDICT = 2'd2;
  localparam logic [1:0] KIND_SPARE   = 2'd3;

  // Accumulator operand selects.
  localparam logic [1:0] ACC_CLEAR = 2'd0;
  localparam logic [1:0] ACC_ADD   = 2'd1;
  localparam logic [1:0] ACC_HOLD  = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [4:0]         weight_index;
    logic signed [15:0] weight_value;
    logic signed [15:0] feature;
    logic [3:0]         label;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [3:0] predicted_class;
    logic       from_training;
  } out_item_t;

  // Datapath operation codes.
  localparam logic [3:0] OP_NOP     = 4'd0;
  localparam logic [3:0] OP_HMAC    = 4'd1;  // hidden sum += w1*x
  localparam logic [3:0] OP_HEND    = 4'd2;  // store hidden sum and sigmoid
  localparam logic [3:0] OP_OMAC    = 4'd3;  // output sum += w2*h
  localparam logic [3:0] OP_OEND    = 4'd4;  // store output, track argmax
  localparam logic [3:0] OP_OERR    = 4'd5;  // output error
  localparam logic [3:0] OP_W2UPD   = 4'd6;  // update one output weight
  localparam logic [3:0] OP_BMAC    = 4'd7;  // back sum += w2*e
  localparam logic [3:0] OP_BEND    = 4'd8;  // hidden error
  localparam logic [3:0] OP_W1UPD   = 4'd9;  // update one hidden weight

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] i;   // outer index
    logic [1:0] j;   // inner index
    logic [3:0] label;
  } dp_cmd_t;

  function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
    if (v > 34'sd32767) return 16'sd32767;
    if (v < -34'sd32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] qround(input logic signed [31:0] p);
    logic signed [31:0] q;
    q = p + 32'sd2048;
    return sat16({{14{q[31]}}, q[31:12]});
  endfunction

  function automatic logic signed [15:0] qadd(input logic signed [15:0] a,
                                              input logic signed [15:0] b);
    return sat16(34'(a) + 34'(b));
  endfunction

  function automatic logic signed [15:0] qsub(input logic signed [15:0] a,
                                              input logic signed [15:0] b);
    return sat16(34'(a) - 34'(b));
  endfunction

  function automatic logic signed [15:0] sigmoid_q(input logic signed [15:0] x);
    logic [16:0] a;
    logic [16:0] y;
    a = x[15] ? 17'(-$signed({x[15], x})) : {1'b0, x};
    if (a >= 17'd20480)     y = 17'd4096;
    else if (a >= 17'd9728) y = (a >> 5) + 17'd3456;
    else if (a >= 17'd4096) y = (a >> 3) + 17'd2560;
    else                    y = (a >> 2) + 17'd2048;
    return x[15] ? 16'(17'd4096 - y) : y[15:0];
  endfunction

endpackage

/* design/mlp_backprop_train_predict.sv */
// Two-layer perceptron, backpropagation training and prediction, Q4.12.
// Weight writes and non-last features are accepted while idle. A last feature
// blocks the input while the prediction or training sequence runs on one shared
// multiplier; its result then waits in an output register, and later items go on
// while it waits. Synchronous active-low reset clears control and sets
// learning_rate to 410; weight stores are undefined until written.
module mlp_backprop_train_predict (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mbp_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mbp_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [11:0]         cfg_data
);
  import mbp_pkg::*;

  logic [11:0] eta_r;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        ov_r;
  out_item_t   od_r;
  logic        tr_r;
  logic        start_r;
  logic [3:0]  lab_r;
  logic        acc, start, feat_en, busy, done, mul2, hold;
  dp_cmd_t     cmd;
  logic [3:0]  best;

  assign in_ready  = !busy && !start_r;
  assign cfg_ready = !busy && !start_r;
  assign hold      = ov_r && !out_ready;

  assign acc   = in_valid && in_ready;
  assign start = acc && in_data.last &&
                 (in_data.kind == KIND_TRAIN || in_data.kind == KIND_PREDICT);
  assign feat_en = acc && (in_data.kind == KIND_TRAIN || in_data.kind == KIND_PREDICT)
                   && cnt_r < 2'(N_IN);

  always_comb begin
    cnt_nxt = cnt_r;
    if (feat_en) cnt_nxt = cnt_r + 2'd1;
    if (start) cnt_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eta_r <= 12'd410; cnt_r <= '0; ov_r <= 1'b0; start_r <= 1'b0; tr_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) eta_r <= cfg_data;
      cnt_r <= cnt_nxt;
      start_r <= start;
      if (start) tr_r <= in_data.kind == KIND_TRAIN;
      if (done) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      od_r.predicted_class <= best;
      od_r.from_training <= tr_r;
    end
  end

  always_ff @(posedge clk) if (start) lab_r <= in_data.label;

  mbp_ctrl u_ctrl (
    .clk, .rst_n,
    .start(start_r), .train(tr_r), .label(lab_r), .hold,
    .cmd, .mul2, .busy, .done
  );

  mbp_datapath u_dp (
    .clk, .rst_n,
    .wr_en(acc && in_data.kind == KIND_WRITE),
    .wr_idx(in_data.weight_index),
    .wr_val(in_data.weight_value),
    .feat_en, .feat_idx(cnt_r), .feat_val(in_data.feature),
    .eta(eta_r), .cmd, .mul2, .best
  );

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

/* design/mbp_datapath.sv */
// Datapath: weight and activation stores, one shared Q4.12 multiplier.
// Depends on mbp_pkg. Products feed accumulate/update combinationally; the first product of a chain is registered.
module mbp_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [4:0]          wr_idx,
  input  logic signed [15:0]  wr_val,
  input  logic                feat_en,
  input  logic [1:0]          feat_idx,
  input  logic signed [15:0]  feat_val,
  input  logic [11:0]         eta,
  input  mbp_pkg::dp_cmd_t    cmd,
  input  logic                mul2,     // second multiply of a chained product
  output logic [3:0]          best
);
  import mbp_pkg::*;

  logic signed [15:0] w1_r [W1_N];
  logic signed [15:0] w2_r [W2_N];
  logic signed [15:0] x_r  [N_IN + 1];
  logic signed [15:0] hs_r [N_HID];
  logic signed [15:0] h_r  [N_HID + 1];
  logic signed [15:0] o_r  [N_OUT];
  logic signed [15:0] oe_r [N_OUT];
  logic signed [15:0] he_r [N_HID];
  logic signed [15:0] acc_r, acc_nxt;
  logic signed [15:0] t_r;          // first product of a chain
  logic [3:0]         best_r, best_nxt;

  logic signed [15:0] ma, mb, prod, sg;
  logic signed [31:0] raw;
  logic [3:0]         w1i, w2i, w2o, w1u;

  assign w1i = 4'(cmd.j) * 4'(N_HID) + 4'(cmd.i);
  assign w2i = 4'(cmd.i) * 4'(N_OUT) + 4'(cmd.j);
  assign w2o = 4'(cmd.j) * 4'(N_OUT) + 4'(cmd.i);
  assign w1u = 4'(cmd.i) * 4'(N_HID) + 4'(cmd.j);
  assign sg  = sigmoid_q(hs_r[cmd.i]);

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      OP_HMAC: begin ma = w1_r[w1i]; mb = x_r[cmd.j]; end
      OP_OMAC: begin ma = w2_r[w2o]; mb = h_r[cmd.j]; end
      OP_W2UPD: begin
        if (!mul2) begin ma = {4'd0, eta}; mb = oe_r[cmd.j]; end
        else begin ma = t_r; mb = h_r[cmd.i]; end
      end
      OP_BMAC: begin ma = w2_r[w2i]; mb = oe_r[cmd.j]; end
      OP_BEND: begin
        if (!mul2) begin ma = sg; mb = ONE_Q - sg; end
        else begin ma = acc_r; mb = t_r; end
      end
      OP_W1UPD: begin
        if (!mul2) begin ma = {4'd0, eta}; mb = he_r[cmd.j]; end
        else begin ma = t_r; mb = x_r[cmd.i]; end
      end
      default: ;
    endcase
  end

  assign raw  = ma * mb;
  assign prod = qround(raw);

  always_comb begin
    acc_nxt  = acc_r;
    best_nxt = best_r;
    unique case (cmd.op)
      OP_HMAC, OP_OMAC, OP_BMAC: acc_nxt = qadd(acc_r, prod);
      OP_HEND, OP_OEND, OP_BEND: if (mul2 || cmd.op != OP_BEND) acc_nxt = '0;
      default: ;
    endcase
    if (cmd.op == OP_OEND) begin
      if (cmd.i == 2'd0 || acc_r > o_r[best_r[1:0]]) best_nxt = 4'(cmd.i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      best_r <= '0;
    end else begin
      acc_r  <= acc_nxt;
      best_r <= best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r <= prod;
    if (wr_en) begin
      if (wr_idx < 5'(W1_N)) w1_r[wr_idx[3:0]] <= wr_val;
      else if (wr_idx < 5'(W_N)) w2_r[4'(wr_idx - 5'(W1_N))] <= wr_val;
    end
    if (feat_en) x_r[feat_idx] <= feat_val;
    x_r[N_IN] <= ONE_Q;
    h_r[N_HID] <= ONE_Q;
    unique case (cmd.op)
      OP_HEND: begin hs_r[cmd.i] <= acc_r; h_r[cmd.i] <= sigmoid_q(acc_r); end
      OP_OEND: o_r[cmd.i] <= acc_r;
      OP_OERR: oe_r[cmd.i] <= qsub(o_r[cmd.i], 4'(cmd.i) == cmd.label ? ONE_Q : 16'sd0);
      OP_W2UPD: if (mul2) w2_r[w2i] <= qsub(w2_r[w2i], prod);
      OP_BEND: if (mul2) he_r[cmd.i] <= prod;
      OP_W1UPD: if (mul2) w1_r[w1u] <= qsub(w1_r[w1u], prod);
      default: ;
    endcase
  end

  assign best = best_r;

endmodule

/* design/mbp_ctrl.sv */
// Controller: sequences forward pass, argmax and backpropagation steps.
// Depends on mbp_pkg; drives mbp_datapath through dp_cmd_t.
module mbp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              train,
  input  logic [3:0]        label,
  input  logic              hold,
  output mbp_pkg::dp_cmd_t  cmd,
  output logic              mul2,
  output logic              busy,
  output logic              done
);
  import mbp_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_HMAC = 4'd1;
  localparam logic [3:0] S_HEND = 4'd2;
  localparam logic [3:0] S_OMAC = 4'd3;
  localparam logic [3:0] S_OEND = 4'd4;
  localparam logic [3:0] S_OERR = 4'd5;
  localparam logic [3:0] S_W2   = 4'd6;
  localparam logic [3:0] S_BMAC = 4'd7;
  localparam logic [3:0] S_BEND = 4'd8;
  localparam logic [3:0] S_W1   = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0] st_r, st_nxt;
  logic [1:0] i_r, i_nxt, j_r, j_nxt;
  logic       ph_r, ph_nxt, tr_r, tr_nxt;
  logic [3:0] lab_r, lab_nxt;

  always_comb begin
    st_nxt = st_r; i_nxt = i_r; j_nxt = j_r; ph_nxt = 1'b0;
    tr_nxt = tr_r; lab_nxt = lab_r;
    unique case (st_r)
      S_IDLE: if (start) begin
        st_nxt = S_HMAC; i_nxt = '0; j_nxt = '0; tr_nxt = train; lab_nxt = label;
      end
      S_HMAC: if (j_r == 2'(N_IN)) st_nxt = S_HEND; else j_nxt = j_r + 2'd1;
      S_HEND: begin
        j_nxt = '0;
        if (i_r == 2'(N_HID - 1)) begin i_nxt = '0; st_nxt = S_OMAC; end
        else begin i_nxt = i_r + 2'd1; st_nxt = S_HMAC; end
      end
      S_OMAC: if (j_r == 2'(N_HID)) st_nxt = S_OEND; else j_nxt = j_r + 2'd1;
      S_OEND: begin
        j_nxt = '0;
        if (i_r == 2'(N_OUT - 1)) begin
          i_nxt = '0; st_nxt = tr_r ? S_OERR : S_DONE;
        end else begin i_nxt = i_r + 2'd1; st_nxt = S_OMAC; end
      end
      S_OERR: if (i_r == 2'(N_OUT - 1)) begin i_nxt = '0; st_nxt = S_W2; end
              else i_nxt = i_r + 2'd1;
      S_W2: begin
        ph_nxt = !ph_r;
        if (ph_r) begin
          if (j_r == 2'(N_OUT - 1)) begin
            j_nxt = '0;
            if (i_r == 2'(N_HID)) begin i_nxt = '0; st_nxt = S_BMAC; end
            else i_nxt = i_r + 2'd1;
          end else j_nxt = j_r + 2'd1;
        end
      end
      S_BMAC: if (j_r == 2'(N_OUT - 1)) st_nxt = S_BEND; else j_nxt = j_r + 2'd1;
      S_BEND: begin
        ph_nxt = !ph_r;
        if (ph_r) begin
          j_nxt = '0;
          if (i_r == 2'(N_HID - 1)) begin i_nxt = '0; st_nxt = S_W1; end
          else begin i_nxt = i_r + 2'd1; st_nxt = S_BMAC; end
        end
      end
      S_W1: begin
        ph_nxt = !ph_r;
        if (ph_r) begin
          if (j_r == 2'(N_HID - 1)) begin
            j_nxt = '0;
            if (i_r == 2'(N_IN)) st_nxt = S_DONE;
            else i_nxt = i_r + 2'd1;
          end else j_nxt = j_r + 2'd1;
        end
      end
      S_DONE: if (!hold) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; i_r <= '0; j_r <= '0; ph_r <= 1'b0; tr_r <= 1'b0; lab_r <= '0;
    end else begin
      st_r <= st_nxt; i_r <= i_nxt; j_r <= j_nxt; ph_r <= ph_nxt;
      tr_r <= tr_nxt; lab_r <= lab_nxt;
    end
  end

  always_comb begin
    cmd.i = i_r; cmd.j = j_r; cmd.label = lab_r;
    unique case (st_r)
      S_HMAC: cmd.op = OP_HMAC;
      S_HEND: cmd.op = OP_HEND;
      S_OMAC: cmd.op = OP_OMAC;
      S_OEND: cmd.op = OP_OEND;
      S_OERR: cmd.op = OP_OERR;
      S_W2:   cmd.op = OP_W2UPD;
      S_BMAC: cmd.op = OP_BMAC;
      S_BEND: cmd.op = OP_BEND;
      S_W1:   cmd.op = OP_W1UPD;
      default: cmd.op = OP_NOP;
    endcase
  end

  assign mul2 = ph_r;
  assign busy = st_r != S_IDLE;
  assign done = st_r == S_DONE && !hold;

endmodule
